[rtl/core/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types and constants for the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int BLOCKS   = 256;
    localparam int IDX_W    = $clog2(BLOCKS);
    localparam int CNT_W    = 9;
    localparam int ADDR_W   = 32;
    localparam int STRIDE_W = 16;
    localparam int SPAN_W   = CNT_W + STRIDE_W;
    localparam int STEP_W   = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_OWNED = 2'd2,
        ST_NONE_USED = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE   = 2'd0,
        CFG_STRIDE = 2'd1,
        CFG_COUNT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } t_state;

    typedef struct packed {
        logic                start;
        logic [SPAN_W-1:0]   dividend;
        logic [STRIDE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] quot;
        logic             exact;
    } t_div_rsp;

endpackage

[rtl/core/fbpa_div.sv]
// ----------------------------------------------------------------------------
// fbpa_div
// restoring divider: block offset over stride, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fbpa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbpa_pkg::t_div_req i_req,
    output fbpa_pkg::t_div_rsp o_rsp
);
    import fbpa_pkg::*;

    logic                r_run;
    logic                r_done;
    logic [STEP_W-1:0]   r_left;
    logic [SPAN_W-1:0]   r_rem;
    logic [SPAN_W-1:0]   r_dsr;
    logic [IDX_W-1:0]    r_quot;
    logic [SPAN_W:0]     trial;

    // dividend is known to be below BLOCKS * divisor, so IDX_W bits of quotient suffice
    assign trial = {1'b0, r_rem} - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_left == '0)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_left <= STEP_W'(IDX_W - 1);
            r_rem  <= i_req.dividend;
            r_dsr  <= SPAN_W'(i_req.divisor) << (IDX_W - 1);
            r_quot <= '0;
        end else if (r_run) begin
            r_left <= r_left - STEP_W'(1);
            r_dsr  <= r_dsr >> 1;
            if (!trial[SPAN_W]) begin
                r_rem  <= trial[SPAN_W-1:0];
                r_quot <= {r_quot[IDX_W-2:0], 1'b1};
            end else begin
                r_quot <= {r_quot[IDX_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.quot  = r_quot;
    assign o_rsp.exact = (r_rem == '0);

endmodule

[rtl/core/fixed_block_pool_allocator_top.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// fixed-size block allocator with a lifo free list held in a link memory
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with o_strobe high, and the receiver
// cannot stall it. Allocate, reset-list, undefined commands and frees of an
// address outside the pool pass through the registered link-memory read at
// the free head and then the execute state, which resolves and registers
// the result. A free of an address inside the pool then runs the restoring
// divider that turns the byte offset into a block index and checks the
// stride alignment, one quotient bit per cycle. The link memory needs no
// clearing pass: a per-entry valid bit, cleared by reset and by the
// reset-list command, makes an untouched entry read as its index plus one.
// Configuration writes are always accepted (o_cfg_ready is tied high) and
// must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_cmd,
    input  logic [fbpa_pkg::ADDR_W-1:0]        i_block_address,
    output logic                               o_strobe,
    output logic [1:0]                         o_status,
    output logic [fbpa_pkg::ADDR_W-1:0]        o_granted_address,
    output logic [fbpa_pkg::CNT_W-1:0]         o_used_count,
    output logic [fbpa_pkg::CNT_W-1:0]         o_available_count,
    output logic [fbpa_pkg::CNT_W-1:0]         o_peak_used,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]        i_cfg_data
);
    import fbpa_pkg::*;

    // configuration registers
    logic [ADDR_W-1:0]   r_base;
    logic [STRIDE_W-1:0] r_stride;
    logic [CNT_W-1:0]    r_count;

    // allocator state
    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [CNT_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_used, n_used;
    logic [CNT_W-1:0]    r_peak, n_peak;
    logic [ADDR_W:0]     r_off;
    logic [SPAN_W-1:0]   r_span;

    // link memory, its valid bits and the registered read port
    logic [CNT_W-1:0]    r_link [BLOCKS];
    logic [BLOCKS-1:0]   r_lvld;
    logic [CNT_W-1:0]    r_rd_data;
    logic                r_rd_vld;

    // result registers
    logic                r_strobe;
    t_status             r_status;
    logic [ADDR_W-1:0]   r_grant;
    logic [CNT_W-1:0]    r_used_o;
    logic [CNT_W-1:0]    r_avail_o;
    logic [CNT_W-1:0]    r_peak_o;

    // combinational controls
    logic                accept;
    logic [CNT_W-1:0]    eff_cnt;
    logic [IDX_W-1:0]    head_idx;
    logic [IDX_W+STRIDE_W-1:0] grant_ofs;
    logic                owned_range;
    logic                n_fire;
    t_status             n_status;
    logic [ADDR_W-1:0]   n_grant;
    logic                link_we;
    logic                link_clr;
    logic [IDX_W-1:0]    link_waddr;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // pool size clamped to the link memory depth
    assign eff_cnt   = (r_count > CNT_W'(BLOCKS)) ? CNT_W'(BLOCKS) : r_count;
    assign head_idx  = r_head[IDX_W-1:0];
    assign grant_ofs = head_idx * r_stride;

    // base <= addr < base + span with no wrap: borrow clear and offset below span
    assign owned_range = !r_off[ADDR_W] && (r_off[ADDR_W-1:0] < ADDR_W'(r_span));

    // configuration transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_stride <= STRIDE_W'(16);
            r_count  <= CNT_W'(BLOCKS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BASE:   r_base   <= i_cfg_data;
                CFG_STRIDE: r_stride <= i_cfg_data[STRIDE_W-1:0];
                CFG_COUNT:  r_count  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    fbpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // next state and result
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_used     = r_used;
        n_peak     = r_peak;
        n_fire     = 1'b0;
        n_status   = ST_OK;
        n_grant    = '0;
        link_we    = 1'b0;
        link_clr   = 1'b0;
        link_waddr = div_rsp.quot;
        div_req.start    = 1'b0;
        div_req.dividend = r_off[SPAN_W-1:0];
        div_req.divisor  = r_stride;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_ALLOC: begin
                        n_fire  = 1'b1;
                        n_state = S_IDLE;
                        if ((r_head >= eff_cnt) || (r_used >= eff_cnt)) begin
                            n_status = ST_EMPTY;
                        end else begin
                            // untouched entries still link to their successor
                            n_head  = r_rd_vld ? r_rd_data : CNT_W'(head_idx) + CNT_W'(1);
                            n_grant = r_base + ADDR_W'(grant_ofs);
                            n_used  = r_used + CNT_W'(1);
                            if (n_used > r_peak) begin
                                n_peak = n_used;
                            end
                        end
                    end
                    CMD_FREE: begin
                        if (owned_range) begin
                            div_req.start = 1'b1;
                            n_state       = S_DIV;
                        end else begin
                            n_fire   = 1'b1;
                            n_status = ST_NOT_OWNED;
                            n_state  = S_IDLE;
                        end
                    end
                    CMD_RESET: begin
                        n_fire   = 1'b1;
                        n_head   = '0;
                        n_used   = '0;
                        link_clr = 1'b1;
                        n_state  = S_IDLE;
                    end
                    default: begin
                        n_fire  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_fire  = 1'b1;
                    n_state = S_IDLE;
                    if (!div_rsp.exact) begin
                        n_status = ST_NOT_OWNED;
                    end else if (r_used == '0) begin
                        n_status = ST_NONE_USED;
                    end else begin
                        // push the freed block onto the list head
                        link_we = 1'b1;
                        n_head  = CNT_W'(div_rsp.quot);
                        n_used  = r_used - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state machine and allocator control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_used  <= '0;
            r_peak  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_used  <= n_used;
            r_peak  <= n_peak;
        end
    end

    // command capture, offset and span registered at the transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_off  <= {1'b0, i_block_address} - {1'b0, r_base};
            r_span <= eff_cnt * r_stride;
        end
    end

    // link memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link[link_waddr] <= r_head;
        end
        if (accept) begin
            r_rd_data <= r_link[head_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld <= '0;
        end else if (link_clr) begin
            r_lvld <= '0;
        end else if (link_we) begin
            r_lvld[link_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_vld <= r_lvld[head_idx];
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_fire) begin
            r_status  <= n_status;
            r_grant   <= n_grant;
            r_used_o  <= n_used;
            r_avail_o <= (eff_cnt > n_used) ? (eff_cnt - n_used) : '0;
            r_peak_o  <= n_peak;
        end
    end

    assign o_strobe          = r_strobe;
    assign o_status          = r_status;
    assign o_granted_address = r_grant;
    assign o_used_count      = r_used_o;
    assign o_available_count = r_avail_o;
    assign o_peak_used       = r_peak_o;

    // one result per command, and the result strobe is never high back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    // the divider only finishes while a free is waiting for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside a free");

    // head index and used count stay within the pool depth
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= CNT_W'(BLOCKS)) && (r_used <= CNT_W'(BLOCKS)))
        else $error("free head or used count beyond pool depth");

    // a successful allocate raises the used count by one
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_cmd == CMD_ALLOC && n_status == ST_OK)
            |=> (r_used == $past(r_used) + CNT_W'(1)))
        else $error("allocate did not count the block");

endmodule

[verif/tb_fixed_block_pool_allocator_top.sv]
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator_top
// self-checking bench for the fixed block pool allocator
// ----------------------------------------------------------------------------
// Commands go in through a start/busy driver that is fed from a backlog
// queue. Configuration writes sit in the same backlog and are only issued
// once the block has gone quiet. At every command transfer a local copy of
// the pool (link store, free head, used count, peak) works out the reply
// and queues it. A monitor then checks each strobed reply against the
// oldest queued one. A short directed run covers the corner cases. Random
// phases follow, each with a fresh pool geometry, and most of their frees
// hit real block addresses so that the free list is kept busy.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator_top;

    import fbpa_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 16;   // slowest command is a free that runs the divider
    localparam int unsigned TAIL_CYCLES  = 32;
    localparam int unsigned RANDOM_ITEMS = 550;

    typedef enum logic {JOB_CMD, JOB_CFG} t_job_kind;

    typedef struct {
        t_job_kind         kind;
        t_cmd              cmd;
        logic [ADDR_W-1:0] addr;
        t_cfg_idx          reg_idx;
        logic [ADDR_W-1:0] reg_data;
        int unsigned       gap;
    } t_pool_job;

    typedef struct {
        t_status           status;
        logic [ADDR_W-1:0] granted;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  avail;
        logic [CNT_W-1:0]  peak;
    } t_pool_reply;

    // dut connections, all inputs known from time zero
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 start           = 1'b0;
    logic                 busy;
    logic [1:0]           i_cmd           = CMD_ALLOC;
    logic [ADDR_W-1:0]    i_block_address = '0;
    logic                 o_strobe;
    logic [1:0]           o_status;
    logic [ADDR_W-1:0]    o_granted_address;
    logic [CNT_W-1:0]     o_used_count;
    logic [CNT_W-1:0]     o_available_count;
    logic [CNT_W-1:0]     o_peak_used;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = CFG_BASE;
    logic [ADDR_W-1:0]    i_cfg_data      = '0;

    // pool model state and its copy of the registers
    logic [CNT_W-1:0]     pool_link [BLOCKS];
    logic [CNT_W-1:0]     pool_head;
    logic [CNT_W-1:0]     pool_used;
    logic [CNT_W-1:0]     pool_peak;
    logic [ADDR_W-1:0]    pool_base;
    logic [STRIDE_W-1:0]  pool_stride;
    logic [CNT_W-1:0]     pool_count;

    // stimulus and reply bookkeeping
    t_pool_job            cmd_backlog [$];
    t_pool_reply          expected_replies [$];
    t_pool_job            job;
    bit                   job_held;
    int unsigned          wait_left;
    int unsigned          settle;
    int unsigned          fail_count;
    int unsigned          reply_no;

    // pool geometry as the stimulus generator sees it
    logic [ADDR_W-1:0]    gen_base   = '0;
    logic [STRIDE_W-1:0]  gen_stride = 16'd16;
    logic [CNT_W-1:0]     gen_count  = 9'd256;
    bit                   quiet_phase;
    int unsigned          queued_cmds;

    fixed_block_pool_allocator_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_block_address   (i_block_address),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_used_count      (o_used_count),
        .o_available_count (o_available_count),
        .o_peak_used       (o_peak_used),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // pool model
    // ------------------------------------------------------------------

    // free list back in ascending order, nothing in use
    task automatic pool_rebuild();
        for (int i = 0; i < BLOCKS; i++) begin
            pool_link[i] = CNT_W'(i + 1);
        end
        pool_head = '0;
        pool_used = '0;
    endtask

    task automatic pool_hw_reset();
        pool_rebuild();
        pool_peak   = '0;
        pool_base   = '0;
        pool_stride = 16'd16;
        pool_count  = 9'd256;
    endtask

    task automatic pool_write_reg(input t_cfg_idx idx, input logic [ADDR_W-1:0] data);
        case (idx)
            CFG_BASE:   pool_base   = data;
            CFG_STRIDE: pool_stride = data[STRIDE_W-1:0];
            CFG_COUNT:  pool_count  = data[CNT_W-1:0];
            default:    ;
        endcase
    endtask

    // applies one command to the model and returns the reply it should give
    task automatic pool_predict(input t_cmd c, input logic [ADDR_W-1:0] a,
                                output t_pool_reply r);
        logic [CNT_W-1:0] lim;
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [63:0]      off;
        logic [63:0]      idx;
        // block_count above the pool size is clamped
        lim       = (pool_count > CNT_W'(BLOCKS)) ? CNT_W'(BLOCKS) : pool_count;
        r.status  = ST_OK;
        r.granted = '0;
        case (c)
            CMD_ALLOC: begin
                // head past the end also counts as empty, e.g. after the pool shrank
                if (pool_head >= lim || pool_used >= lim) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.granted = pool_base + ADDR_W'(pool_head) * ADDR_W'(pool_stride);
                    pool_head = pool_link[pool_head];
                    pool_used = pool_used + CNT_W'(1);
                    if (pool_used > pool_peak) pool_peak = pool_used;
                end
            end
            CMD_FREE: begin
                // range check is done wide so that it never wraps
                lo = 64'(pool_base);
                hi = lo + 64'(lim) * 64'(pool_stride);
                if (64'(a) < lo || 64'(a) >= hi || pool_stride == '0) begin
                    r.status = ST_NOT_OWNED;
                end else begin
                    off = 64'(a) - lo;
                    if (off % 64'(pool_stride) != 0) begin
                        r.status = ST_NOT_OWNED;
                    end else if (pool_used == '0) begin
                        r.status = ST_NONE_USED;
                    end else begin
                        // double frees are not caught, the block just goes on again
                        idx = off / 64'(pool_stride);
                        if (idx < BLOCKS) begin
                            pool_link[idx] = pool_head;
                            pool_head      = CNT_W'(idx);
                        end
                        pool_used = pool_used - CNT_W'(1);
                    end
                end
            end
            CMD_RESET: pool_rebuild();
            default:   ;
        endcase
        r.used  = pool_used;
        r.avail = (lim > pool_used) ? lim - pool_used : '0;
        r.peak  = pool_peak;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [ADDR_W-1:0] block_addr(input int unsigned k);
        return gen_base + ADDR_W'(k) * ADDR_W'(gen_stride);
    endfunction

    task automatic queue_cmd(input t_cmd c, input logic [ADDR_W-1:0] a);
        t_pool_job j;
        j.kind     = JOB_CMD;
        j.cmd      = c;
        j.addr     = a;
        j.reg_idx  = CFG_BASE;
        j.reg_data = '0;
        j.gap      = quiet_phase ? 0 : $urandom_range(0, 15);
        cmd_backlog.push_back(j);
        queued_cmds++;
    endtask

    task automatic queue_reg(input t_cfg_idx idx, input logic [ADDR_W-1:0] data);
        t_pool_job j;
        j.kind     = JOB_CFG;
        j.cmd      = CMD_NOP;
        j.addr     = '0;
        j.reg_idx  = idx;
        j.reg_data = data;
        j.gap      = quiet_phase ? 0 : $urandom_range(0, 15);
        cmd_backlog.push_back(j);
    endtask

    // unused upper bits of stride and count carry junk, the block must mask them
    task automatic configure_pool(input logic [ADDR_W-1:0] b, input logic [STRIDE_W-1:0] s,
                                  input logic [CNT_W-1:0] n);
        gen_base   = b;
        gen_stride = s;
        gen_count  = n;
        queue_reg(CFG_COUNT, {23'($urandom), n});
        queue_reg(CFG_BASE, b);
        queue_reg(CFG_STRIDE, {16'($urandom), s});
    endtask

    // mostly allocs and frees of real block addresses, plus some noise
    task automatic queue_random_phase(input int unsigned len, input int unsigned alloc_pct);
        int unsigned r;
        int unsigned k;
        int unsigned lim;
        lim = (gen_count > BLOCKS) ? BLOCKS : gen_count;
        for (int unsigned i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            k = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
            if (r < alloc_pct) begin
                queue_cmd(CMD_ALLOC, $urandom);
            end else if (r < 88) begin
                queue_cmd(CMD_FREE, block_addr(k));
            end else if (r < 91 && gen_stride > 1) begin
                queue_cmd(CMD_FREE, block_addr(k) + $urandom_range(1, gen_stride - 1));
            end else if (r < 94) begin
                queue_cmd(CMD_FREE, $urandom);
            end else if (r < 97) begin
                queue_cmd(CMD_RESET, $urandom);
            end else begin
                queue_cmd(CMD_NOP, $urandom);
            end
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // driver: one job at a time from the backlog, gap first, then the
    // transfer; register writes wait for the block to drain
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        t_pool_reply want;
        logic        start_nxt;
        logic        cfg_nxt;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            job_held    = 1'b0;
            pool_hw_reset();
        end else begin
            start_nxt = start;
            cfg_nxt   = i_cfg_valid;
            // command transfer: the model moves on and the reply is queued
            if (start && !busy) begin
                pool_predict(t_cmd'(i_cmd), i_block_address, want);
                expected_replies.push_back(want);
                start_nxt = 1'b0;
                job_held  = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                pool_write_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
                cfg_nxt  = 1'b0;
                job_held = 1'b0;
            end
            if (!start_nxt && !cfg_nxt) begin
                if (!job_held && cmd_backlog.size() != 0) begin
                    job       = cmd_backlog.pop_front();
                    job_held  = 1'b1;
                    wait_left = job.gap;
                    settle    = 0;
                end
                if (job_held) begin
                    if (wait_left != 0) begin
                        wait_left--;
                    end else if (job.kind == JOB_CMD) begin
                        i_cmd           <= job.cmd;
                        i_block_address <= job.addr;
                        start_nxt       = 1'b1;
                    end else if (expected_replies.size() != 0 || busy) begin
                        // block still working, restart the quiet count
                        settle = 0;
                    end else if (settle < DRAIN_CYCLES) begin
                        settle++;
                    end else begin
                        i_cfg_index <= job.reg_idx;
                        i_cfg_data  <= job.reg_data;
                        cfg_nxt     = 1'b1;
                    end
                end
            end
            start       <= start_nxt;
            i_cfg_valid <= cfg_nxt;
        end
    end

    // ------------------------------------------------------------------
    // monitor: every strobe must match the oldest outstanding reply
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_pool_reply want;
        if (i_rst_n && o_strobe) begin
            reply_no++;
            if (expected_replies.size() == 0) begin
                note_failure($sformatf("reply %0d: unexpected, status %0d granted %h",
                                       reply_no, o_status, o_granted_address));
            end else begin
                want = expected_replies.pop_front();
                if (o_status !== want.status || o_granted_address !== want.granted ||
                    o_used_count !== want.used || o_available_count !== want.avail ||
                    o_peak_used !== want.peak) begin
                    note_failure($sformatf({"reply %0d mismatch (exp/act): status %0d/%0d ",
                                            "granted %h/%h used %0d/%0d avail %0d/%0d ",
                                            "peak %0d/%0d"},
                                           reply_no, want.status, o_status,
                                           want.granted, o_granted_address,
                                           want.used, o_used_count,
                                           want.avail, o_available_count,
                                           want.peak, o_peak_used));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [ADDR_W-1:0]   b;
        logic [STRIDE_W-1:0] s;
        logic [CNT_W-1:0]    n;
        quiet_phase = 1'b0;
        queued_cmds = 0;
        fail_count  = 0;
        reply_no    = 0;

        // reset geometry: base 0, stride 16, 256 blocks
        queue_cmd(CMD_FREE, 32'h0);              // owned block but nothing in use
        queue_cmd(CMD_ALLOC, 32'hFFFF_FFFF);
        queue_cmd(CMD_ALLOC, 32'h0);
        queue_cmd(CMD_ALLOC, $urandom);
        queue_cmd(CMD_FREE, 32'h8);              // off the stride grid
        queue_cmd(CMD_FREE, 32'h1000);           // one past the last block
        queue_cmd(CMD_FREE, 32'hFFFF_FFFF);
        queue_cmd(CMD_FREE, 32'h10);
        queue_cmd(CMD_ALLOC, $urandom);          // last freed comes back first
        queue_cmd(CMD_FREE, 32'h20);
        queue_cmd(CMD_FREE, 32'h20);             // double free goes through
        queue_cmd(CMD_NOP, 32'hA5A5_5A5A);
        queue_cmd(CMD_RESET, $urandom);          // peak survives the list reset
        queue_cmd(CMD_ALLOC, $urandom);

        // pool straddling the top of the address space: grants wrap, range does not
        configure_pool(32'hFFFF_FF00, 16'h0040, 9'd8);
        repeat (8) queue_cmd(CMD_ALLOC, $urandom);
        queue_cmd(CMD_FREE, 32'h0000_0000);
        queue_cmd(CMD_FREE, 32'hFFFF_FFC0);

        // zero stride owns nothing
        configure_pool(32'h0000_1000, 16'h0000, 9'd4);
        queue_cmd(CMD_ALLOC, $urandom);
        queue_cmd(CMD_FREE, 32'h0000_1000);

        // empty pool
        configure_pool(32'h0000_2000, 16'd4, 9'd0);
        queue_cmd(CMD_ALLOC, $urandom);
        queue_cmd(CMD_FREE, 32'h0000_2000);

        // register extremes, count above the pool size gets clamped
        configure_pool(32'h0, 16'hFFFF, 9'h1FF);
        queue_cmd(CMD_RESET, $urandom);
        queue_random_phase(40, 70);
        configure_pool(32'hFFFF_FFFF, 16'd4, 9'd1);
        queue_random_phase(20, 50);

        while (queued_cmds < RANDOM_ITEMS) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       b = 32'h0;
                1:       b = 32'hFFFF_FFFF - $urandom_range(0, 4095);
                default: b = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       s = 16'hFFFF;
                1:       s = STRIDE_W'($urandom_range(0, 3));
                2:       s = STRIDE_W'($urandom);
                default: s = STRIDE_W'($urandom_range(4, 64));
            endcase
            case ($urandom_range(0, 7))
                0:       n = CNT_W'($urandom_range(200, 511));
                1:       n = CNT_W'($urandom_range(1, 3));
                default: n = CNT_W'($urandom_range(1, 24));
            endcase
            configure_pool(b, s, n);
            if ($urandom_range(0, 1) == 0) queue_cmd(CMD_RESET, $urandom);
            queue_random_phase($urandom_range(20, 50), $urandom_range(30, 80));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent and every reply back, then a quiet tail
        do begin
            @(posedge i_clk);
        end while (cmd_backlog.size() != 0 || job_held || start ||
                   expected_replies.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // hang guard, well above the slowest legal run
    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[fixed_block_pool_allocator_top.f]
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_div.sv
rtl/core/fixed_block_pool_allocator_top.sv
verif/tb_fixed_block_pool_allocator_top.sv
